/* sv/tfdsc_pkg.sv */
// Shared types and constants for the tagged frame deframer with sum check.
package tfdsc_pkg;

	localparam int unsigned FRAME_LEN = 17;
	localparam int unsigned POS_W     = 5;
	localparam int unsigned BODY_LEN  = 12;
	localparam int unsigned BODY_IDX_W = 4;
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_W = 1;

	localparam logic [POS_W-1:0] SUM_POS   = POS_W'(FRAME_LEN - 1);
	localparam logic [POS_W-1:0] BODY_POS  = POS_W'(4);

	localparam logic [7:0] TAG0 = 8'h44;
	localparam logic [7:0] TAG1 = 8'h33;
	localparam logic [7:0] TAG2 = 8'h22;
	localparam logic [7:0] TAG3 = 8'h11;

	localparam logic [31:0] BANK_A_ID = 32'd3100;
	localparam logic [31:0] BANK_B_ID = 32'd3106;

	typedef enum logic [1:0] {
		BANK_NONE = 2'd0,
		BANK_A    = 2'd1,
		BANK_B    = 2'd2
	} bank_t;

	typedef struct packed {
		logic [31:0] frame_id;
		logic [15:0] value_0;
		logic [15:0] value_1;
		logic [15:0] value_2;
		logic [15:0] value_3;
	} frame_t;

endpackage

/* sv/tfdsc_front.sv */
// Front end: takes bytes, tracks position, tag and running sum, emits good frames.
module tfdsc_front
	import tfdsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       q_push,
	output frame_t     q_data
);

	logic [POS_W-1:0]      pos_q;
	logic [7:0]            sum_q;
	logic                  tag_ok_q;
	logic [7:0]            body_q [BODY_LEN];
	logic                  accept;
	logic                  closing;
	logic                  good;
	logic [BODY_IDX_W-1:0] body_idx;

	// Only the closing beat has to wait on the queue.
	assign full     = (pos_q == SUM_POS) && q_full;
	assign accept   = push && !full;
	assign closing  = (pos_q >= SUM_POS);
	assign good     = tag_ok_q && (rx_byte == sum_q);
	assign body_idx = BODY_IDX_W'(pos_q[BODY_IDX_W-1:0] - BODY_IDX_W'(BODY_POS));

	assign q_push = accept && closing && good;
	always_comb begin
		q_data.frame_id = {body_q[3], body_q[2], body_q[1], body_q[0]};
		q_data.value_0  = {body_q[5], body_q[4]};
		q_data.value_1  = {body_q[7], body_q[6]};
		q_data.value_2  = {body_q[9], body_q[8]};
		q_data.value_3  = {body_q[11], body_q[10]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			sum_q    <= '0;
			tag_ok_q <= 1'b0;
		end else if (accept) begin
			if (pos_q == '0 && rx_byte != TAG0) begin
				pos_q    <= '0;
				sum_q    <= '0;
				tag_ok_q <= 1'b0;
			end else if (closing) begin
				pos_q    <= '0;
				sum_q    <= '0;
				tag_ok_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
				sum_q <= sum_q + rx_byte;
				case (pos_q)
					POS_W'(0): tag_ok_q <= 1'b1;
					POS_W'(1): tag_ok_q <= tag_ok_q && (rx_byte == TAG1);
					POS_W'(2): tag_ok_q <= tag_ok_q && (rx_byte == TAG2);
					POS_W'(3): tag_ok_q <= tag_ok_q && (rx_byte == TAG3);
					default:   tag_ok_q <= tag_ok_q;
				endcase
			end
		end
	end

	// Body bytes 4..15; every one is rewritten before a frame can close.
	always_ff @(posedge clk) begin
		if (accept && pos_q >= BODY_POS && pos_q < SUM_POS)
			body_q[body_idx] <= rx_byte;
	end

endmodule

/* sv/tfdsc_queue.sv */
// Short frame queue between front and back ends.
module tfdsc_queue
	import tfdsc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr_en,
	input  frame_t wr_data,
	output logic   q_full,
	input  logic   rd_en,
	output logic   q_empty,
	output frame_t rd_data
);

	frame_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign q_full  = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + (QUEUE_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_PTR_W+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

/* sv/tfdsc_back.sv */
// Back end: decodes the bank and holds the result in the output register.
module tfdsc_back
	import tfdsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  frame_t      q_data,
	output logic        q_pop,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] frame_id,
	output logic [15:0] value_0,
	output logic [15:0] value_1,
	output logic [15:0] value_2,
	output logic [15:0] value_3,
	output logic [1:0]  bank
);

	logic   out_valid_q;
	frame_t out_q;
	bank_t  bank_q;
	bank_t  bank_d;

	assign q_pop = !q_empty && (!out_valid_q || pop);

	always_comb begin
		if (q_data.frame_id == BANK_A_ID)
			bank_d = BANK_A;
		else if (q_data.frame_id == BANK_B_ID)
			bank_d = BANK_B;
		else
			bank_d = BANK_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop)
			out_valid_q <= 1'b1;
		else if (pop)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			out_q  <= q_data;
			bank_q <= bank_d;
		end
	end

	assign empty    = !out_valid_q;
	assign frame_id = out_q.frame_id;
	assign value_0  = out_q.value_0;
	assign value_1  = out_q.value_1;
	assign value_2  = out_q.value_2;
	assign value_3  = out_q.value_3;
	assign bank     = bank_q;

endmodule

/* sv/tagged_frame_deframer_sum_check_top.sv */
// Top level of the tagged frame deframer with 8-bit sum check.
// Takes one received byte per cycle with no gaps needed between frames. A
// 17-byte frame opening 44 33 22 11 whose last byte equals the wrapping sum
// of the first sixteen gives one result. The edge accepting the check beat
// writes it into the frame queue; it loads the output register once that
// is free, then shows on the result ports. Other frames vanish silently; a
// first byte other than 0x44 is simply skipped. The front end only holds off
// input (full high) on a check beat while the two-entry frame queue is full,
// so results left waiting cost at most that one beat position per frame.
module tagged_frame_deframer_sum_check_top
	import tfdsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] frame_id,
	output logic [15:0] value_0,
	output logic [15:0] value_1,
	output logic [15:0] value_2,
	output logic [15:0] value_3,
	output logic [1:0]  bank
);

	logic   q_full;
	logic   q_empty;
	logic   q_push;
	logic   q_pop;
	frame_t q_wr_data;
	frame_t q_rd_data;

	tfdsc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.rx_byte (rx_byte),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_data  (q_wr_data)
	);

	tfdsc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_empty (q_empty),
		.rd_data (q_rd_data)
	);

	tfdsc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_rd_data),
		.q_pop    (q_pop),
		.empty    (empty),
		.pop      (pop),
		.frame_id (frame_id),
		.value_0  (value_0),
		.value_1  (value_1),
		.value_2  (value_2),
		.value_3  (value_3),
		.bank     (bank)
	);

endmodule
